### src/liu_pkg.sv
// ----------------------------------------------------------------------------
// liu_pkg: shared definitions of the linear interpolation upsampler
// Widths, limits, emission codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package liu_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_INSERT  = 61;
  localparam int MAX_IN_LEN  = 1024;

  localparam int LEN_W  = 11;   // in_length register
  localparam int OLEN_W = 16;   // out_length register and emitted count
  localparam int CFG_W  = (LEN_W > OLEN_W) ? LEN_W : OLEN_W;
  localparam int GAP_W  = $clog2(MAX_IN_LEN);
  localparam int INS_W  = $clog2(MAX_INSERT + 2);

  // Shared divider: dividend is |b - a| or (out - in), divisor is (in - 1) or (step + 1).
  localparam int DIVD_W = (SAMPLE_BITS > OLEN_W) ? SAMPLE_BITS : OLEN_W;
  localparam int DIVS_W = (GAP_W > INS_W) ? GAP_W : INS_W;
  localparam int DCNT_W = $clog2(DIVD_W);

  localparam logic [LEN_W-1:0] IN_LEN_MAX = LEN_W'(MAX_IN_LEN);
  localparam logic [GAP_W-1:0] GAP_MAX    = GAP_W'(MAX_IN_LEN - 1);
  localparam logic [INS_W-1:0] INS_MAX    = INS_W'(MAX_INSERT);

  // Configuration register indexes.
  localparam logic REG_IN_LEN  = 1'b0;
  localparam logic REG_OUT_LEN = 1'b1;

  typedef logic [1:0] emit_kind_t;
  localparam emit_kind_t EMIT_A   = 2'd0;  // earlier sample of the gap
  localparam emit_kind_t EMIT_PT  = 2'd1;  // next inserted point
  localparam emit_kind_t EMIT_REP = 2'd2;  // repeat of the last point
  localparam emit_kind_t EMIT_B   = 2'd3;  // final sample of the sequence

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       div_gap;
    logic       take_cfg;
    logic       take_gap;
    logic       emit;
    emit_kind_t emit_kind;
    logic       emit_final;
    logic       commit;
  } liu_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic in_last;
    logic div_done;
    logic out_free;
    logic ppg_nz;
    logic pt_last;
    logic do_extra;
  } liu_sts_t;

endpackage

### src/liu_div.sv
// ----------------------------------------------------------------------------
// liu_div: restoring divider
// Unsigned division, one quotient bit per cycle; result held until next start.
// ----------------------------------------------------------------------------
module liu_div import liu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quot,
  output logic [DIVS_W-1:0] rem
);

  logic [DIVS_W-1:0] dsr;
  logic [DCNT_W-1:0] cnt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   trial_sub;
  logic              fits;

  assign trial     = {rem, quot[DIVD_W-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DCNT_W'(1);
      if (cnt == DCNT_W'(DIVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= fits ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quot <= {quot[DIVD_W-2:0], fits};
    end
  end

  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst) !(busy && done))
    else $error("divider busy and done together");

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");

  a_done_holds: assert property (@(posedge clk) disable iff (rst) (done && !start) |=> done)
    else $error("divider result dropped before the next start");

endmodule

### src/liu_dp.sv
// ----------------------------------------------------------------------------
// liu_dp: upsampler datapath
// Sample and count registers, interpolation accumulator, output register.
// ----------------------------------------------------------------------------
module liu_dp import liu_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  liu_cmd_t                      cmd,
  output liu_sts_t                      sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  logic [LEN_W-1:0]              in_length,
  input  logic [OLEN_W-1:0]             out_length,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [SAMPLE_BITS-1:0]        m_value,
  output logic                          m_run_last,
  output logic                          m_seq_done
);

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] b_smp;
  logic signed [SAMPLE_BITS-1:0] pt;
  logic                          have_prev;
  logic                          last_r;
  logic [GAP_W-1:0]              gap_index;
  logic [OLEN_W-1:0]             count;
  logic [INS_W-1:0]              ppg;
  logic [DIVS_W-1:0]             extra;
  logic                          neg;
  logic [DIVD_W-1:0]             q0;
  logic [INS_W-1:0]              r0;
  logic [SAMPLE_BITS-1:0]        acc_q;
  logic [INS_W-1:0]              acc_r;
  logic [INS_W-1:0]              j_cnt;

  // Divider operands.
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          mag;
  logic [LEN_W-1:0]              inl_c;
  logic                          cfg_deg;
  logic [DIVD_W-1:0]             cfg_dvd;
  logic [DIVS_W-1:0]             cfg_dvs;
  logic [DIVD_W-1:0]             div_dvd;
  logic [DIVS_W-1:0]             div_dvs;
  logic                          div_busy;
  logic                          div_done;
  logic [DIVD_W-1:0]             div_quot;
  logic [DIVS_W-1:0]             div_rem;

  assign diff    = {in_sample[SAMPLE_BITS-1], in_sample} - {prev[SAMPLE_BITS-1], prev};
  assign mag     = diff[SAMPLE_BITS] ? -diff : diff;
  assign inl_c   = (in_length > IN_LEN_MAX) ? IN_LEN_MAX : in_length;
  assign cfg_deg = (in_length < LEN_W'(2)) || (out_length <= OLEN_W'(inl_c));
  assign cfg_dvd = cfg_deg ? '0 : DIVD_W'(out_length - OLEN_W'(inl_c));
  assign cfg_dvs = cfg_deg ? DIVS_W'(1) : DIVS_W'(inl_c - LEN_W'(1));
  assign div_dvd = cmd.div_gap ? DIVD_W'(mag[SAMPLE_BITS-1:0]) : cfg_dvd;
  assign div_dvs = cmd.div_gap ? DIVS_W'(ppg) + DIVS_W'(1) : cfg_dvs;

  liu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Next inserted point: the quotient of |b-a|*j / (step+1) advances by q0 and
  // the remainder by r0, with one carry when the remainder wraps.
  logic [INS_W-1:0]              divs;
  logic [INS_W:0]                acc_r_sum;
  logic                          carry;
  logic [INS_W:0]                acc_r_wrap;
  logic [SAMPLE_BITS-1:0]        acc_q_nx;
  logic [INS_W-1:0]              acc_r_nx;
  logic signed [SAMPLE_BITS+1:0] offs;
  logic signed [SAMPLE_BITS+1:0] pt_sum;
  logic [SAMPLE_BITS-1:0]        pt_calc;

  assign divs       = ppg + INS_W'(1);
  assign acc_r_sum  = {1'b0, acc_r} + {1'b0, r0};
  assign carry      = acc_r_sum >= {1'b0, divs};
  assign acc_r_wrap = acc_r_sum - {1'b0, divs};
  assign acc_r_nx   = carry ? acc_r_wrap[INS_W-1:0] : acc_r_sum[INS_W-1:0];
  assign acc_q_nx   = acc_q + q0[SAMPLE_BITS-1:0] + SAMPLE_BITS'(carry);
  assign offs       = neg ? -$signed({2'b00, acc_q_nx}) : $signed({2'b00, acc_q_nx});
  assign pt_sum     = {{2{prev[SAMPLE_BITS-1]}}, prev} + offs;
  assign pt_calc    = pt_sum[SAMPLE_BITS-1:0];

  logic [SAMPLE_BITS-1:0] emit_val;
  logic [OLEN_W-1:0]      cnt_inc;
  logic                   emit_ok;
  logic                   hit_len;

  always_comb begin
    unique case (cmd.emit_kind)
      EMIT_A:   emit_val = prev;
      EMIT_PT:  emit_val = pt_calc;
      EMIT_REP: emit_val = pt;
      EMIT_B:   emit_val = b_smp;
      default:  emit_val = prev;
    endcase
  end

  assign emit_ok = cmd.emit && (count < out_length);
  assign cnt_inc = count + OLEN_W'(1);
  assign hit_len = cnt_inc == out_length;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      gap_index <= '0;
      count     <= '0;
      m_valid   <= 1'b0;
    end else begin
      if (cmd.load_in && !have_prev && !in_last) begin
        have_prev <= 1'b1;
      end
      if (emit_ok) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (cmd.commit && last_r) begin
        have_prev <= 1'b0;
        gap_index <= '0;
        count     <= '0;
      end else begin
        if (emit_ok) begin
          count <= cnt_inc;
        end
        if (cmd.commit && (gap_index < GAP_MAX)) begin
          gap_index <= gap_index + GAP_W'(1);
        end
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      b_smp  <= in_sample;
      last_r <= in_last;
      neg    <= diff[SAMPLE_BITS];
      if (!have_prev) begin
        prev <= in_sample;
      end
    end
    if (cmd.take_cfg) begin
      ppg   <= (div_quot > DIVD_W'(MAX_INSERT)) ? INS_MAX : div_quot[INS_W-1:0];
      extra <= div_rem;
    end
    if (cmd.take_gap) begin
      q0    <= div_quot;
      r0    <= div_rem[INS_W-1:0];
      acc_q <= '0;
      acc_r <= '0;
      j_cnt <= '0;
    end
    if (cmd.emit) begin
      if (cmd.emit_kind == EMIT_A) begin
        pt <= prev;
      end else if (cmd.emit_kind == EMIT_PT) begin
        pt    <= pt_calc;
        acc_q <= acc_q_nx;
        acc_r <= acc_r_nx;
        j_cnt <= j_cnt + INS_W'(1);
      end
    end
    if (emit_ok) begin
      m_value    <= emit_val;
      m_run_last <= cmd.emit_final || hit_len;
      m_seq_done <= hit_len || (cmd.emit_kind == EMIT_B);
    end
    if (cmd.commit && !last_r) begin
      prev <= b_smp;
    end
  end

  always_comb begin
    sts.have_prev = have_prev;
    sts.in_last   = last_r;
    sts.div_done  = div_done;
    sts.out_free  = !m_valid || m_ready;
    sts.ppg_nz    = ppg != '0;
    sts.pt_last   = (j_cnt + INS_W'(1)) == ppg;
    sts.do_extra  = DIVS_W'(gap_index) < extra;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      emit_ok |-> (!m_valid || m_ready))
    else $error("output register overwritten while held");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
      (m_valid && m_seq_done) |-> m_run_last)
    else $error("sequence end without run end");

  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
      cmd.emit |-> !div_busy)
    else $error("emission while divider busy");

endmodule

### src/liu_ctrl.sv
// ----------------------------------------------------------------------------
// liu_ctrl: upsampler controller
// Sequences derivation, gap division and the emissions of each gap.
// ----------------------------------------------------------------------------
module liu_ctrl import liu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output liu_cmd_t cmd,
  input  liu_sts_t sts
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_CFG  = 3'd1;
  localparam logic [2:0] S_DIV_GAP  = 3'd2;
  localparam logic [2:0] S_EMIT_A   = 3'd3;
  localparam logic [2:0] S_EMIT_PT  = 3'd4;
  localparam logic [2:0] S_EMIT_REP = 3'd5;
  localparam logic [2:0] S_EMIT_B   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = state == S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (sts.have_prev) begin
            cmd.div_start = 1'b1;
            cmd.div_gap   = 1'b1;
            state_next    = S_DIV_GAP;
          end else if (in_last) begin
            state_next = S_EMIT_B;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV_CFG;
          end
        end
      end
      S_DIV_CFG: begin
        if (sts.div_done) begin
          cmd.take_cfg = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DIV_GAP: begin
        if (sts.div_done) begin
          cmd.take_gap = 1'b1;
          state_next   = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_A;
          cmd.emit_final = !sts.ppg_nz && !sts.do_extra && !sts.in_last;
          priority if (sts.ppg_nz) begin
            state_next = S_EMIT_PT;
          end else if (sts.do_extra) begin
            state_next = S_EMIT_REP;
          end else if (sts.in_last) begin
            state_next = S_EMIT_B;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_PT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_PT;
          cmd.emit_final = sts.pt_last && !sts.do_extra && !sts.in_last;
          priority if (!sts.pt_last) begin
            state_next = S_EMIT_PT;
          end else if (sts.do_extra) begin
            state_next = S_EMIT_REP;
          end else if (sts.in_last) begin
            state_next = S_EMIT_B;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_REP: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_REP;
          cmd.emit_final = !sts.in_last;
          if (sts.in_last) begin
            state_next = S_EMIT_B;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_B: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = EMIT_B;
          cmd.emit_final = 1'b1;
          cmd.commit     = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> sts.out_free)
    else $error("emission without room in the output register");

  a_pt_needs_step: assert property (@(posedge clk) disable iff (rst)
      (state == S_EMIT_PT) |-> sts.ppg_nz)
    else $error("inserted point with zero points per gap");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
      cmd.commit |=> (state == S_IDLE))
    else $error("commit did not return to idle");

endmodule

### src/linear_interp_upsampler_top.sv
// A gap-closing sample is accepted, divided by the shared bit-serial divider and
// its quotient taken before its first result, then one result a cycle while the
// output register is free. Input is taken only in idle, so each sample holds the
// input until its division and emissions are done; a lone final sample skips the
// divider. Output stalls hold it longer.
// Reset (rst, synchronous): idle, no sequence open, in_length 3, out_length 25.
// ----------------------------------------------------------------------------
// linear_interp_upsampler_top: linear interpolation upsampler
// Stretches a stream of Q8.8 samples from in_length points to out_length
// points by inserting evenly spaced, truncated interpolation points.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_top import liu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Input samples.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
  input  logic                   s_tlast,   // seq_end
  // Stretched samples.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_BITS-1:0] m_tdata,   // [15:0] value
  output logic                   m_tlast,   // run_last
  output logic                   m_tuser,   // [0] seq_done
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // Configuration registers. Writes are always accepted; the lengths are
  // sampled by the datapath when the first sample of a sequence arrives,
  // and out_length is also compared live against the emitted count.
  logic [LEN_W-1:0]  in_length;
  logic [OLEN_W-1:0] out_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_length  <= LEN_W'(3);
      out_length <= OLEN_W'(25);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_LEN:  in_length  <= cfg_data[LEN_W-1:0];
        REG_OUT_LEN: out_length <= cfg_data[OLEN_W-1:0];
        default:     in_length  <= in_length;
      endcase
    end
  end

  // The controller walks each gap through division and emission; the
  // datapath holds the samples, counters and the output register.
  liu_cmd_t cmd;
  liu_sts_t sts;

  liu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The output register decouples the two sides: a new input transaction is
  // taken in idle even while the last result still waits to be taken.
  liu_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (s_tdata),
    .in_last    (s_tlast),
    .in_length  (in_length),
    .out_length (out_length),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_value    (m_tdata),
    .m_run_last (m_tlast),
    .m_seq_done (m_tuser)
  );

  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready) |=> !s_tready || !sts.have_prev || $past(!sts.have_prev))
    else $error("input accepted during gap processing");

  a_tuser_tlast: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready && m_tuser) |-> m_tlast)
    else $error("sequence end delivered without run end");

  a_div_follows_gap: assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready && sts.have_prev) |=> !s_tready)
    else $error("gap sample did not start division");

endmodule

### bench/linear_interp_upsampler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_interp_upsampler_top_test: self-checking bench for the upsampler
// Feeds Q8.8 sample sequences under a range of length settings, predicts every
// stretched sample in the bench and checks each output transaction in order.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_top_test;
  import liu_pkg::*;

  localparam int          HALF_PERIOD    = 6;
  localparam int          RESET_CYCLES   = 4;
  localparam int          SETTLE_CYCLES  = 80;    // quiet time before a write and at the end
  localparam int unsigned RANDOM_SAMPLES = 250;
  localparam int unsigned RESET_IN_LEN   = 3;
  localparam int unsigned RESET_OUT_LEN  = 25;
  localparam int unsigned OUT_LEN_MAX    = (1 << OLEN_W) - 1;
  localparam logic [31:0] CYCLE_LIMIT    = 32'd12_000_000;

  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_PAUSE} stim_kind_t;

  typedef struct {
    stim_kind_t             kind;
    logic [SAMPLE_BITS-1:0] data;
    logic                   last;
    logic                   index;
    logic [CFG_W-1:0]       wdata;
  } stim_op_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   run_last;
    logic                   seq_done;
  } point_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_BITS-1:0] s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [SAMPLE_BITS-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  linear_interp_upsampler_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pending stimulus, filled once at time zero and drained by the driver.
  stim_op_t    stim_q[$];
  int unsigned planned_samples;

  // Bench copy of the block: registers, sequence state and expected output.
  int unsigned in_len_reg;
  int unsigned out_len_reg;
  int          prev_value;
  bit          have_prev;
  int unsigned gap_idx;
  int unsigned emitted;
  int unsigned pts_per_gap;
  int unsigned extra_gaps;
  point_t      expected_points[$];

  // Run bookkeeping.
  logic [31:0] cycle_cnt;
  int          idle_cycles;
  int unsigned hold_off;
  int unsigned stall_left;
  int unsigned n_errors;
  int unsigned n_samples;
  int unsigned n_points;
  int unsigned n_writes;
  int unsigned n_sequences;
  stim_op_t    op;
  point_t      want;

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Per-sequence split of the extra length: points inserted in every gap and
  // how many leading gaps get one repeated point on top.
  function automatic void split_gaps();
    int unsigned inl;
    inl = (in_len_reg > MAX_IN_LEN) ? MAX_IN_LEN : in_len_reg;
    pts_per_gap = 0;
    extra_gaps  = 0;
    if (inl >= 2 && out_len_reg > inl) begin
      pts_per_gap = (out_len_reg - inl) / (inl - 1);
      if (pts_per_gap > MAX_INSERT) pts_per_gap = MAX_INSERT;
      extra_gaps = (out_len_reg - inl) % (inl - 1);
    end
  endfunction

  function automatic void close_sequence();
    prev_value = 0;
    have_prev  = 1'b0;
    gap_idx    = 0;
    emitted    = 0;
  endfunction

  // Nothing goes out once the stretched sequence has reached its length.
  function automatic void push_point(int v, bit ends_seq);
    point_t p;
    if (emitted < out_len_reg) begin
      emitted++;
      p.value    = SAMPLE_BITS'(v);
      p.run_last = 1'b0;
      p.seq_done = ends_seq || (emitted == out_len_reg);
      expected_points = {expected_points, p};
    end
  endfunction

  function automatic void stretch_sample(logic signed [SAMPLE_BITS-1:0] smp, logic seq_end);
    int          a;
    int          b;
    int          pt;
    int unsigned j;
    int unsigned queued_before;
    b = smp;
    queued_before = expected_points.size();
    if (!have_prev) begin
      split_gaps();
      if (seq_end) begin
        push_point(b, 1'b1);
        close_sequence();
      end else begin
        prev_value = b;
        have_prev  = 1'b1;
      end
    end else begin
      a  = prev_value;
      pt = a;
      push_point(a, 1'b0);
      for (j = 1; j <= pts_per_gap; j++) begin
        pt = a + ((b - a) * int'(j)) / int'(pts_per_gap + 1);
        push_point(pt, 1'b0);
      end
      if (gap_idx < extra_gaps) push_point(pt, 1'b0);
      if (seq_end) begin
        push_point(b, 1'b1);
        close_sequence();
      end else begin
        prev_value = b;
        if (gap_idx < MAX_IN_LEN - 1) gap_idx++;
      end
    end
    if (expected_points.size() > queued_before) begin
      expected_points[expected_points.size() - 1].run_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  function automatic void plan_sample(logic [SAMPLE_BITS-1:0] v, logic last);
    stim_op_t s;
    s.kind  = OP_SAMPLE;
    s.data  = v;
    s.last  = last;
    s.index = REG_IN_LEN;
    s.wdata = '0;
    stim_q = {stim_q, s};
    planned_samples++;
  endfunction

  function automatic void plan_write(logic idx, logic [CFG_W-1:0] val);
    stim_op_t s;
    s.kind  = OP_WRITE;
    s.data  = '0;
    s.last  = 1'b0;
    s.index = idx;
    s.wdata = val;
    stim_q = {stim_q, s};
  endfunction

  // The sender holds off until every expected result has been taken.
  function automatic void plan_pause();
    stim_op_t s;
    s.kind  = OP_PAUSE;
    s.data  = '0;
    s.last  = 1'b0;
    s.index = REG_IN_LEN;
    s.wdata = '0;
    stim_q = {stim_q, s};
  endfunction

  // One sequence of random content: full-scale values, small steps between
  // neighbors (where truncation shows) and arbitrary values, with occasional pauses.
  function automatic void plan_sequence(int unsigned len);
    logic [SAMPLE_BITS-1:0] v;
    int unsigned            k;
    v = SAMPLE_BITS'($urandom);
    for (k = 1; k <= len; k++) begin
      case ($urandom_range(0, 7))
        0:       v = SMP_MAX;
        1:       v = SMP_MIN;
        2, 3:    v = v + SAMPLE_BITS'($urandom_range(0, 31) - 16);
        default: v = SAMPLE_BITS'($urandom);
      endcase
      if (len > 3 && $urandom_range(0, 19) == 0) plan_pause();
      plan_sample(v, k == len);
    end
  endfunction

  // Groups of sequences, each under a freshly written out_length and mostly a
  // new in_length. With an effective in_length of 16 or less, most sequences
  // have exactly that many; others run one longer, hold one sample or 2 to 12.
  task automatic plan_random_phase();
    int unsigned inl;
    int unsigned outl;
    int unsigned eff;
    int unsigned len;
    int unsigned nseq;
    logic [CFG_W-1:0] wdata;
    inl = RESET_IN_LEN;
    while (planned_samples < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 11))
          0:       inl = 2;
          1:       inl = $urandom_range(0, 1);
          2:       inl = $urandom_range(MAX_IN_LEN + 1, (1 << LEN_W) - 1);
          3:       inl = MAX_IN_LEN;
          4:       inl = $urandom_range(9, MAX_IN_LEN - 1);
          default: inl = $urandom_range(3, 8);
        endcase
        wdata = '0;
        if ($urandom_range(0, 2) == 0) wdata = CFG_W'($urandom);
        wdata[LEN_W-1:0] = LEN_W'(inl);
        plan_write(REG_IN_LEN, wdata);
      end
      eff = (inl > MAX_IN_LEN) ? MAX_IN_LEN : ((inl < 2) ? 2 : inl);
      case ($urandom_range(0, 9))
        0:       outl = 0;
        1:       outl = OUT_LEN_MAX;
        2:       outl = $urandom_range(0, eff);
        3:       outl = $urandom_range(2, OUT_LEN_MAX);
        default: outl = eff + $urandom_range(1, eff * 20);
      endcase
      if (outl > OUT_LEN_MAX) outl = OUT_LEN_MAX;
      plan_write(REG_OUT_LEN, CFG_W'(outl));
      for (nseq = $urandom_range(1, 3); nseq != 0; nseq--) begin
        case ($urandom_range(0, 7))
          0:       len = 1;
          1:       len = $urandom_range(2, 12);
          2:       len = (eff <= 16) ? eff + 1 : $urandom_range(2, 12);
          default: len = (eff <= 16) ? eff : $urandom_range(2, 12);
        endcase
        plan_sequence(len);
      end
    end
  endtask

  // Mostly short gaps, a few long ones, and none at all while bits 11:10 of the
  // cycle counter are both set.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (cycle_cnt[11:10] == 2'b11 || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: sample and register write transactions from the pending queue.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
      hold_off  <= 0;
    end else if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
      // A transaction is still open; keep it on the bus unchanged.
    end else if (hold_off != 0) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
      hold_off  <= hold_off - 1;
    end else if (stim_q.size() == 0) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      op = stim_q[0];
      case (op.kind)
        OP_SAMPLE: begin
          s_tvalid  <= 1'b1;
          s_tdata   <= op.data;
          s_tlast   <= op.last;
          cfg_valid <= 1'b0;
          hold_off  <= pick_gap();
          stim_q.delete(0);
        end
        OP_WRITE: begin
          // Registers change only when the block has been quiet long enough
          // to have finished any sample that produced no output.
          s_tvalid <= 1'b0;
          if (!s_tvalid && idle_cycles >= SETTLE_CYCLES) begin
            cfg_valid <= 1'b1;
            cfg_index <= op.index;
            cfg_data  <= op.wdata;
            stim_q.delete(0);
          end else begin
            cfg_valid <= 1'b0;
          end
        end
        default: begin
          s_tvalid  <= 1'b0;
          cfg_valid <= 1'b0;
          if (!s_tvalid && idle_cycles != 0) stim_q.delete(0);
        end
      endcase
    end
  end

  // Output back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: updates the predictor on every accepted write or sample and
  // checks every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_len_reg  = RESET_IN_LEN;
      out_len_reg = RESET_OUT_LEN;
      close_sequence();
      split_gaps();
      expected_points.delete();
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IN_LEN) in_len_reg = cfg_data[LEN_W-1:0];
        else                         out_len_reg = cfg_data[OLEN_W-1:0];
        n_writes++;
      end
      if (s_tvalid && s_tready) begin
        stretch_sample(s_tdata, s_tlast);
        n_samples++;
        if (s_tlast) n_sequences++;
      end
      if (m_tvalid && m_tready) begin
        n_points++;
        if (expected_points.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected: value %h run_last %b seq_done %b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = expected_points.pop_front();
          if (m_tdata !== want.value) begin
            n_errors++;
            $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
          end
          if (m_tlast !== want.run_last) begin
            n_errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.run_last, m_tlast);
          end
          if (m_tuser !== want.seq_done) begin
            n_errors++;
            $display("%0t: seq_done expected %b actual %b", $time, want.seq_done, m_tuser);
          end
        end
      end
      idle_cycles <= (expected_points.size() == 0 && !s_tvalid) ? idle_cycles + 1 : 0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_points.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tlast         = 1'b0;
    m_tready        = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_IN_LEN;
    cfg_data        = '0;
    cycle_cnt       = '0;
    idle_cycles     = 0;
    hold_off        = 0;
    stall_left      = 0;
    planned_samples = 0;
    n_errors        = 0;
    n_samples       = 0;
    n_points        = 0;
    n_writes        = 0;
    n_sequences     = 0;

    // Reset lengths (3 -> 25): full-scale swings both ways, then a sequence
    // made of a single sample.
    plan_sample(SMP_MAX, 1'b0);
    plan_sample(SMP_MIN, 1'b0);
    plan_sample(SMP_MAX, 1'b1);
    plan_sample(16'h1234, 1'b1);
    // Two samples stretched to the longest output: insertion saturates.
    plan_write(REG_IN_LEN, CFG_W'(2));
    plan_write(REG_OUT_LEN, CFG_W'(OUT_LEN_MAX));
    plan_sample(SMP_MIN, 1'b0);
    plan_sample(SMP_MAX, 1'b1);
    // in_length below two: plain copy, with a drain in the middle.
    plan_write(REG_IN_LEN, CFG_W'(1));
    plan_write(REG_OUT_LEN, CFG_W'(10));
    plan_sample(16'd100, 1'b0);
    plan_pause();
    plan_sample(-16'sd100, 1'b0);
    plan_sample(16'd7, 1'b1);
    // in_length above the limit, written with the unused data bits set.
    plan_write(REG_IN_LEN, '1);
    plan_write(REG_OUT_LEN, CFG_W'(1500));
    plan_sample(16'h0100, 1'b0);
    plan_sample(16'hFF00, 1'b0);
    plan_sample(16'h0081, 1'b1);
    // Zero lengths: nothing comes out at all.
    plan_write(REG_IN_LEN, CFG_W'(0));
    plan_write(REG_OUT_LEN, CFG_W'(0));
    plan_sample(16'h5555, 1'b0);
    plan_sample(16'hAAAA, 1'b1);
    // Output shorter than the input, and more samples than in_length: the
    // output length is reached in the middle of the sequence.
    plan_write(REG_IN_LEN, CFG_W'(5));
    plan_write(REG_OUT_LEN, CFG_W'(4));
    plan_sequence(6);

    planned_samples = 0;
    plan_random_phase();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(stim_q.size() == 0 && !s_tvalid && !cfg_valid && idle_cycles >= SETTLE_CYCLES))
      @(negedge clk);

    $display("Run covered %0d samples in %0d sequences and %0d register writes,",
             n_samples, n_sequences, n_writes);
    $display("with %0d stretched samples checked under random stalls on both sides.",
             n_points);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### linear_interp_upsampler_top.f
src/liu_pkg.sv
src/liu_div.sv
src/liu_dp.sv
src/liu_ctrl.sv
src/linear_interp_upsampler_top.sv
bench/linear_interp_upsampler_top_test.sv
